[rtl/core/kspb_pkg.sv]
// ---------------------------------------------------------------------------
// kspb_pkg
// Shared types and constants for the knight shortest-path search block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package kspb_pkg;

  // Largest distance that fits the three-bit distance field.
  localparam logic [2:0] DIST_MAX = 3'd7;

  // Number of knight jumps tried from each square.
  localparam int unsigned JUMP_COUNT = 8;

  // Column and row offsets of the eight knight jumps, in search order.
  localparam logic signed [2:0] JUMP_COL [JUMP_COUNT] = '{
    -3'sd2, -3'sd2, -3'sd1, -3'sd1, 3'sd1, 3'sd1, 3'sd2, 3'sd2
  };
  localparam logic signed [2:0] JUMP_ROW [JUMP_COUNT] = '{
    -3'sd1, 3'sd1, -3'sd2, 3'sd2, -3'sd2, 3'sd2, -3'sd1, 3'sd1
  };

  // Status of one candidate square, passed from the jump unit to the walker.
  typedef struct packed {
    logic on_board;
    logic is_target;
  } nb_t;

endpackage

`default_nettype wire

[rtl/core/knight_shortest_path_bfs.sv]
// ---------------------------------------------------------------------------
// knight_shortest_path_bfs
// Least number of knight moves between two squares, found by a
// breadth-first walk over a distance map and a square queue held in RAM.
// ---------------------------------------------------------------------------
//
// Channel   Direction  Handshake             Payload
// request   in         in_valid / in_ready   start_col, start_row, target_col, target_row
// result    out        out_valid / out_ready move_count, unreachable
//
// Each request first sweeps the distance map clean, one square a cycle,
// then seeds the queue with the start square. Each dequeued square is
// read from the queue (POP, LOAD), then its jumps are tried in turn: an
// off-board jump is passed over in CHECK, an on-board jump reads the map in
// CHECK and updates it in PROBE. Equal or off-board squares skip the walk.
// Reset clears the control state only; both memories are left as they are.
// A new request is taken while the previous result still waits on out_ready.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module knight_shortest_path_bfs #(
  parameter int unsigned BOARD_SIZE = 8
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [2:0] start_col,
  input  wire logic [2:0] start_row,
  input  wire logic [2:0] target_col,
  input  wire logic [2:0] target_row,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic      [2:0] move_count,
  output logic            unreachable
);

  import kspb_pkg::*;

  localparam int unsigned SQ      = BOARD_SIZE * BOARD_SIZE;
  localparam int unsigned COORD_W = $clog2(BOARD_SIZE);
  localparam int unsigned IDX_W   = $clog2(SQ);
  localparam int unsigned CNT_W   = $clog2(SQ + 1);
  localparam int unsigned QW      = 2 * COORD_W + 3;

  typedef enum logic [2:0] {
    IDLE, CLEAR, SEED, POP, LOAD, CHECK, PROBE, EMIT
  } state_t;

  state_t               state;
  logic [IDX_W-1:0]     clr_cnt;
  logic [CNT_W-1:0]     head;
  logic [CNT_W-1:0]     tail;
  logic [2:0]           jump_sel;
  logic [COORD_W-1:0]   cur_col;
  logic [COORD_W-1:0]   cur_row;
  logic [2:0]           cur_dist;
  logic [COORD_W-1:0]   src_col;
  logic [COORD_W-1:0]   src_row;
  logic [COORD_W-1:0]   tgt_col;
  logic [COORD_W-1:0]   tgt_row;
  logic [2:0]           res_count;
  logic                 res_unreach;

  // Distance map: {visited, distance}, and the square queue: {row, col, distance}.
  logic [3:0]           dmem [SQ];
  logic [QW-1:0]        qmem [SQ];
  logic                 dm_we;
  logic [IDX_W-1:0]     dm_waddr;
  logic [3:0]           dm_wdata;
  logic [IDX_W-1:0]     dm_raddr;
  logic [3:0]           dm_rdata;
  logic                 qm_we;
  logic [IDX_W-1:0]     qm_waddr;
  logic [QW-1:0]        qm_wdata;
  logic [IDX_W-1:0]     qm_raddr;
  logic [QW-1:0]        qm_rdata;

  nb_t                  nb;
  logic [COORD_W-1:0]   nb_col;
  logic [COORD_W-1:0]   nb_row;
  logic [IDX_W-1:0]     nb_addr;
  logic [IDX_W-1:0]     src_addr;
  logic [2:0]           dist_next;
  logic                 in_fire;
  logic                 off_board;
  logic                 same_square;
  logic                 out_free;

  // Jump unit for the current square and jump.
  kspb_jump #(
    .BOARD_SIZE (BOARD_SIZE)
  ) u_jump (
    .cur_col  (cur_col),
    .cur_row  (cur_row),
    .jump_sel (jump_sel),
    .tgt_col  (tgt_col),
    .tgt_row  (tgt_row),
    .nb       (nb),
    .nb_col   (nb_col),
    .nb_row   (nb_row),
    .nb_addr  (nb_addr)
  );

  // Handshake and request classification.
  assign in_ready    = (state == IDLE);
  assign in_fire     = in_valid && in_ready;
  assign out_free    = !out_valid || out_ready;
  assign same_square = (start_col == target_col) && (start_row == target_row);
  assign off_board   = ({2'b00, start_col}  >= 5'(BOARD_SIZE)) ||
                       ({2'b00, start_row}  >= 5'(BOARD_SIZE)) ||
                       ({2'b00, target_col} >= 5'(BOARD_SIZE)) ||
                       ({2'b00, target_row} >= 5'(BOARD_SIZE));
  assign src_addr    = IDX_W'(src_row) * IDX_W'(BOARD_SIZE) + IDX_W'(src_col);
  assign dist_next   = (cur_dist == DIST_MAX) ? DIST_MAX : cur_dist + 3'd1;

  // Memory port control for each state.
  always_comb begin
    dm_we    = 1'b0;
    dm_waddr = nb_addr;
    dm_wdata = {1'b1, dist_next};
    dm_raddr = nb_addr;
    qm_we    = 1'b0;
    qm_waddr = tail[IDX_W-1:0];
    qm_wdata = {nb_row, nb_col, dist_next};
    qm_raddr = head[IDX_W-1:0];
    unique case (state)
      CLEAR: begin
        dm_we    = 1'b1;
        dm_waddr = clr_cnt;
        dm_wdata = 4'd0;
      end
      SEED: begin
        dm_we    = 1'b1;
        dm_waddr = src_addr;
        dm_wdata = {1'b1, 3'd0};
        qm_we    = 1'b1;
        qm_waddr = '0;
        qm_wdata = {src_row, src_col, 3'd0};
      end
      PROBE: begin
        dm_we = !dm_rdata[3];
        qm_we = !dm_rdata[3] && !nb.is_target && (tail < CNT_W'(SQ));
      end
      default: begin
      end
    endcase
  end

  // Distance map with a registered read port.
  always_ff @(posedge clk) begin
    if (dm_we) begin
      dmem[dm_waddr] <= dm_wdata;
    end
    dm_rdata <= dmem[dm_raddr];
  end

  // Square queue with a registered read port.
  always_ff @(posedge clk) begin
    if (qm_we) begin
      qmem[qm_waddr] <= qm_wdata;
    end
    qm_rdata <= qmem[qm_raddr];
  end

  // Walk sequencer and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
      head      <= '0;
      tail      <= '0;
    end else begin
      // A result handed over here is dropped, unless a new one loads below.
      if (out_valid && out_ready && (state != EMIT)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (in_fire) begin
            src_col <= COORD_W'(start_col);
            src_row <= COORD_W'(start_row);
            tgt_col <= COORD_W'(target_col);
            tgt_row <= COORD_W'(target_row);
            clr_cnt <= '0;
            if (same_square) begin
              res_count   <= 3'd0;
              res_unreach <= 1'b0;
              state       <= EMIT;
            end else if (off_board) begin
              res_count   <= 3'd0;
              res_unreach <= 1'b1;
              state       <= EMIT;
            end else begin
              state <= CLEAR;
            end
          end
        end
        CLEAR: begin
          if (clr_cnt == IDX_W'(SQ - 1)) begin
            state <= SEED;
          end else begin
            clr_cnt <= clr_cnt + 1'b1;
          end
        end
        SEED: begin
          head  <= '0;
          tail  <= CNT_W'(1);
          state <= POP;
        end
        POP: begin
          if (head < tail) begin
            head  <= head + 1'b1;
            state <= LOAD;
          end else begin
            res_count   <= 3'd0;
            res_unreach <= 1'b1;
            state       <= EMIT;
          end
        end
        LOAD: begin
          cur_row  <= qm_rdata[QW-1 -: COORD_W];
          cur_col  <= qm_rdata[COORD_W+2 -: COORD_W];
          cur_dist <= qm_rdata[2:0];
          jump_sel <= 3'd0;
          state    <= CHECK;
        end
        CHECK: begin
          if (nb.on_board) begin
            state <= PROBE;
          end else if (jump_sel == 3'(JUMP_COUNT - 1)) begin
            state <= POP;
          end else begin
            jump_sel <= jump_sel + 3'd1;
          end
        end
        PROBE: begin
          if (!dm_rdata[3] && nb.is_target) begin
            res_count   <= dist_next;
            res_unreach <= 1'b0;
            state       <= EMIT;
          end else begin
            if (qm_we) begin
              tail <= tail + 1'b1;
            end
            if (jump_sel == 3'(JUMP_COUNT - 1)) begin
              state <= POP;
            end else begin
              jump_sel <= jump_sel + 3'd1;
              state    <= CHECK;
            end
          end
        end
        EMIT: begin
          if (out_free) begin
            move_count  <= res_count;
            unreachable <= res_unreach;
            out_valid   <= 1'b1;
            state       <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  // The queue never grows past the board and is never read beyond its fill.
  a_tail_bound: assert property (@(posedge clk) disable iff (rst)
    tail <= CNT_W'(SQ))
    else $error("queue tail beyond board size");

  a_head_tail: assert property (@(posedge clk) disable iff (rst)
    head <= tail)
    else $error("queue head passed tail");

  // A map probe always follows the cycle that issued its read.
  a_probe_order: assert property (@(posedge clk) disable iff (rst)
    state == PROBE |-> $past(state) == CHECK)
    else $error("map probe without a preceding read");

  // An unreachable result carries a zero move count.
  a_unreach_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && unreachable |-> move_count == 3'd0)
    else $error("unreachable result with nonzero move count");

endmodule

`default_nettype wire

[rtl/core/kspb_jump.sv]
// ---------------------------------------------------------------------------
// kspb_jump
// Applies one knight jump to the current square, checks the board edges,
// forms the map address of the new square and compares it with the target.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kspb_jump #(
  parameter int unsigned BOARD_SIZE = 8
) (
  input  wire logic [$clog2(BOARD_SIZE)-1:0]              cur_col,
  input  wire logic [$clog2(BOARD_SIZE)-1:0]              cur_row,
  input  wire logic [2:0]                                 jump_sel,
  input  wire logic [$clog2(BOARD_SIZE)-1:0]              tgt_col,
  input  wire logic [$clog2(BOARD_SIZE)-1:0]              tgt_row,
  output kspb_pkg::nb_t                                   nb,
  output logic      [$clog2(BOARD_SIZE)-1:0]              nb_col,
  output logic      [$clog2(BOARD_SIZE)-1:0]              nb_row,
  output logic      [$clog2(BOARD_SIZE*BOARD_SIZE)-1:0]   nb_addr
);

  import kspb_pkg::*;

  localparam int unsigned COORD_W = $clog2(BOARD_SIZE);
  localparam int unsigned SW      = COORD_W + 2;
  localparam int unsigned IDX_W   = $clog2(BOARD_SIZE * BOARD_SIZE);

  logic signed [SW-1:0] new_col;
  logic signed [SW-1:0] new_row;
  logic signed [SW-1:0] edge_lim;

  // Signed offset arithmetic so that a jump past the low edge goes negative.
  always_comb begin
    edge_lim = $signed(SW'(BOARD_SIZE));
    new_col  = $signed({2'b00, cur_col}) + SW'(JUMP_COL[jump_sel]);
    new_row  = $signed({2'b00, cur_row}) + SW'(JUMP_ROW[jump_sel]);
    nb_col   = new_col[COORD_W-1:0];
    nb_row   = new_row[COORD_W-1:0];
    nb.on_board = (new_col >= 0) && (new_col < edge_lim) &&
                  (new_row >= 0) && (new_row < edge_lim);
    nb.is_target = (nb_col == tgt_col) && (nb_row == tgt_row);
    nb_addr = IDX_W'(nb_row) * IDX_W'(BOARD_SIZE) + IDX_W'(nb_col);
  end

endmodule

`default_nettype wire

[tb/knight_shortest_path_bfs_test.sv]
// ---------------------------------------------------------------------------
// knight_shortest_path_bfs_test
// Self-checking bench for the knight minimum-move search block. A short
// table of hand-picked requests (equal squares, opposite corners, every
// knight jump) is followed by random requests. Each result is compared
// with the table's known answer or with a breadth-first search kept inside
// the bench. Both handshakes see random gaps, with some stretches run at full rate.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module knight_shortest_path_bfs_test;

  localparam int BOARD           = 8;
  localparam int SQUARES         = BOARD * BOARD;
  localparam int RANDOM_REQUESTS = 1150;
  localparam int PHASE_LENGTH    = 128;
  localparam int IDLE_LIMIT      = 20000;
  localparam int TAIL_CYCLES     = 1300;
  localparam int REPORT_LIMIT    = 10;

  typedef struct packed {
    logic [2:0] move_count;
    logic       unreachable;
  } answer_t;

  // One row of the hand-picked table; when typed is set, mc is the known answer.
  typedef struct packed {
    logic [2:0] sc;
    logic [2:0] sr;
    logic [2:0] tc;
    logic [2:0] tr;
    logic       typed;
    logic [2:0] mc;
  } probe_t;

  logic       clk         = 1'b0;
  logic       rst         = 1'b1;
  logic       in_valid    = 1'b0;
  logic       in_ready;
  logic [2:0] start_col   = 3'd0;
  logic [2:0] start_row   = 3'd0;
  logic [2:0] target_col  = 3'd0;
  logic [2:0] target_row  = 3'd0;
  logic       out_valid;
  logic       out_ready   = 1'b0;
  logic [2:0] move_count;
  logic       unreachable;

  answer_t pending_answers [$];
  int      error_count = 0;
  int      idle_cycles = 0;
  bit      calm        = 1'b0;

  probe_t probes [23] = '{
    '{3'd0, 3'd0, 3'd0, 3'd0, 1'b1, 3'd0},
    '{3'd7, 3'd7, 3'd7, 3'd7, 1'b1, 3'd0},
    '{3'd3, 3'd4, 3'd3, 3'd4, 1'b1, 3'd0},
    '{3'd0, 3'd0, 3'd7, 3'd7, 1'b1, 3'd6},
    '{3'd7, 3'd7, 3'd0, 3'd0, 1'b1, 3'd6},
    '{3'd0, 3'd7, 3'd7, 3'd0, 1'b1, 3'd6},
    '{3'd7, 3'd0, 3'd0, 3'd7, 1'b1, 3'd6},
    '{3'd3, 3'd3, 3'd1, 3'd2, 1'b1, 3'd1},
    '{3'd3, 3'd3, 3'd1, 3'd4, 1'b1, 3'd1},
    '{3'd3, 3'd3, 3'd2, 3'd1, 1'b1, 3'd1},
    '{3'd3, 3'd3, 3'd2, 3'd5, 1'b1, 3'd1},
    '{3'd3, 3'd3, 3'd4, 3'd1, 1'b1, 3'd1},
    '{3'd3, 3'd3, 3'd4, 3'd5, 1'b1, 3'd1},
    '{3'd3, 3'd3, 3'd5, 3'd2, 1'b1, 3'd1},
    '{3'd3, 3'd3, 3'd5, 3'd4, 1'b1, 3'd1},
    '{3'd7, 3'd7, 3'd5, 3'd6, 1'b1, 3'd1},
    '{3'd0, 3'd0, 3'd2, 3'd1, 1'b1, 3'd1},
    '{3'd0, 3'd0, 3'd1, 3'd1, 1'b0, 3'd0},
    '{3'd7, 3'd7, 3'd6, 3'd6, 1'b0, 3'd0},
    '{3'd0, 3'd0, 3'd0, 3'd1, 1'b0, 3'd0},
    '{3'd7, 3'd0, 3'd7, 3'd1, 1'b0, 3'd0},
    '{3'd0, 3'd0, 3'd7, 3'd0, 1'b0, 3'd0},
    '{3'd5, 3'd6, 3'd2, 3'd1, 1'b0, 3'd0}
  };

  knight_shortest_path_bfs #(
    .BOARD_SIZE(BOARD)
  ) u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .start_col  (start_col),
    .start_row  (start_row),
    .target_col (target_col),
    .target_row (target_row),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .move_count (move_count),
    .unreachable(unreachable)
  );

  // Free-running clock.
  initial begin
    forever #4 clk = ~clk;
  end

  // Breadth-first search over the board; returns the least number of moves.
  function automatic answer_t knight_distance(input logic [2:0] sc, input logic [2:0] sr,
                                              input logic [2:0] tc, input logic [2:0] tr);
    bit         seen [SQUARES];
    logic [2:0] hops [SQUARES];
    int         fifo [SQUARES];
    int         head;
    int         tail;
    int         cur;
    int         cc;
    int         cr;
    int         nc;
    int         nr;
    int         ni;
    answer_t    ans;
    ans = '0;
    if (sc == tc && sr == tr) begin
      return ans;
    end
    if (sc >= BOARD || sr >= BOARD || tc >= BOARD || tr >= BOARD) begin
      ans.unreachable = 1'b1;
      return ans;
    end
    for (int i = 0; i < SQUARES; i++) begin
      seen[i] = 1'b0;
      hops[i] = 3'd0;
    end
    fifo[0] = sr * BOARD + sc;
    seen[fifo[0]] = 1'b1;
    head = 0;
    tail = 1;
    while (head < tail) begin
      cur = fifo[head];
      cc  = cur % BOARD;
      cr  = cur / BOARD;
      head++;
      // A knight jump is any offset pair whose product is plus or minus two.
      for (int dc = -2; dc <= 2; dc++) begin
        for (int dr = -2; dr <= 2; dr++) begin
          if (dc * dr == 2 || dc * dr == -2) begin
            nc = cc + dc;
            nr = cr + dr;
            if (nc >= 0 && nc < BOARD && nr >= 0 && nr < BOARD) begin
              ni = nr * BOARD + nc;
              if (!seen[ni]) begin
                seen[ni] = 1'b1;
                hops[ni] = (hops[cur] == 3'd7) ? 3'd7 : hops[cur] + 3'd1;
                if (nc == tc && nr == tr) begin
                  ans.move_count = hops[ni];
                  return ans;
                end
                fifo[tail] = ni;
                tail++;
              end
            end
          end
        end
      end
    end
    ans.unreachable = 1'b1;
    return ans;
  endfunction

  // Counts a failure, reporting only the first few in full.
  task automatic note_error(input string msg);
    if (error_count < REPORT_LIMIT) begin
      $display("%0t: %s", $realtime, msg);
    end
    error_count++;
  endtask

  // Offers one request, after a random gap unless the phase is calm, and records its expected answer.
  task automatic send_request(input logic [2:0] sc, input logic [2:0] sr,
                              input logic [2:0] tc, input logic [2:0] tr,
                              input answer_t want);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    start_col  <= sc;
    start_row  <= sr;
    target_col <= tc;
    target_row <= tr;
    do @(posedge clk); while (in_ready !== 1'b1);
    pending_answers = {pending_answers, want};
  endtask

  // Holds off new requests until every outstanding answer has come back.
  task automatic drain_answers();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_answers.size() > 0);
  endtask

  // Request side: reset, hand-picked table, then random requests in phases.
  initial begin
    logic [2:0] sc;
    logic [2:0] sr;
    logic [2:0] tc;
    logic [2:0] tr;
    answer_t    want;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    for (int r = 0; r < $size(probes); r++) begin
      if (probes[r].typed) begin
        want = '{move_count: probes[r].mc, unreachable: 1'b0};
      end else begin
        want = knight_distance(probes[r].sc, probes[r].sr, probes[r].tc, probes[r].tr);
      end
      send_request(probes[r].sc, probes[r].sr, probes[r].tc, probes[r].tr, want);
    end
    drain_answers();

    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      // Each phase either runs flat out or with random gaps; some end drained.
      if (n % PHASE_LENGTH == 0) begin
        if (n > 0 && $urandom_range(0, 1) == 0) begin
          drain_answers();
        end
        calm = ($urandom_range(0, 3) == 0);
      end
      sc = 3'($urandom_range(0, 7));
      sr = 3'($urandom_range(0, 7));
      tc = 3'($urandom_range(0, 7));
      tr = 3'($urandom_range(0, 7));
      if ($urandom_range(0, 9) == 0) begin
        tc = sc;
        tr = sr;
      end
      send_request(sc, sr, tc, tr, knight_distance(sc, sr, tc, tr));
    end
    in_valid <= 1'b0;

    while (pending_answers.size() > 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Result side: random back-pressure, then a field-by-field comparison.
  initial begin
    int      stall;
    answer_t want;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 4);
      if (stall > 0) begin
        out_ready <= 1'b0;
        do @(posedge clk); while (out_valid !== 1'b1);
        repeat (stall - 1) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      if (pending_answers.size() == 0) begin
        note_error($sformatf("result with no request waiting: move_count %0d unreachable %0b",
                             move_count, unreachable));
      end else begin
        want = pending_answers.pop_front();
        if (move_count !== want.move_count || unreachable !== want.unreachable) begin
          note_error($sformatf("mismatch: move_count exp %0d got %0d, unreachable exp %0b got %0b",
                               want.move_count, move_count, want.unreachable, unreachable));
        end
      end
    end
  end

  // Watchdog: ends the run when no request or result moves for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == IDLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

endmodule
